[sv/ternary_heap_priority_queue_macros.svh]
// Assertion macros shared by the heap queue RTL.
`ifndef TERNARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define TERNARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define THPQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define THPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define THPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define THPQ_ASSERT_ALWAYS(lbl, cond, msg)
`define THPQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define THPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/thpq_pkg.sv]
// Types and constants of the ternary heap priority queue.
`timescale 1ns / 1ps
package thpq_pkg;

    localparam int DEPTH      = 1024;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int FILL_W     = 11;
    // Wide enough for the third child of the last entry.
    localparam int CH_W       = ADDR_W + 2;

    // Division by three through a reciprocal; exact for values below 2**17.
    localparam int DIV3_SHIFT = 17;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 1) / 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                  op;
        logic [ELEM_WIDTH-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] top_value;
        logic [1:0]            status;
        logic [FILL_W-1:0]     fill_count;
    } t_rsp;

endpackage

[sv/thpq_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module thpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ternary_heap_priority_queue.sv]
// Insert: the value rises a level per parent read and compare, the parent moving down,
// until it settles or reaches the root. Remove: the last element sinks from the root
// (one RAM read port, three child reads per level) unless the heap empties; up to 6
// levels at 1024 entries. A dropped insert or a remove from an empty heap skips the store.
// One request is in work at a time; the next is taken while the result waits.
// Reset is synchronous: fill count, order mode and control clear, the store does not.
`timescale 1ns / 1ps
`include "ternary_heap_priority_queue_macros.svh"
module ternary_heap_priority_queue
    import thpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_UP_RD   = 10'b00_0000_0010,
        S_UP_CMP  = 10'b00_0000_0100,
        S_RM_LAST = 10'b00_0000_1000,
        S_RM_LOAD = 10'b00_0001_0000,
        S_DN_RD1  = 10'b00_0010_0000,
        S_DN_RD2  = 10'b00_0100_0000,
        S_DN_RD3  = 10'b00_1000_0000,
        S_DN_CMP  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_order_mode;
    logic [ELEM_WIDTH-1:0] r_val, n_val;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [ADDR_W-1:0]     r_par, n_par;
    logic [CH_W-1:0]       r_first, n_first;
    logic [ELEM_WIDTH-1:0] r_best_val, n_best_val;
    logic [ADDR_W-1:0]     r_best_idx, n_best_idx;
    logic [ELEM_WIDTH-1:0] r_top, n_top;
    logic [1:0]            r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    logic                  in_acc;
    logic [CH_W-1:0]       first_idx;
    logic [CH_W-1:0]       count_ext;
    logic [ADDR_W-1:0]     parent_idx;

    // True when b belongs strictly above a.
    function automatic logic ranks_above(input logic mode, input logic [ELEM_WIDTH-1:0] a,
                                         input logic [ELEM_WIDTH-1:0] b);
        logic res;
        res = mode ? (b < a) : (a < b);
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] div3(input logic [ADDR_W-1:0] x);
        logic [ADDR_W+DIV3_SHIFT-1:0] prod;
        prod = (ADDR_W+DIV3_SHIFT)'(x) * (ADDR_W+DIV3_SHIFT)'(DIV3_MUL);
        return prod[ADDR_W+DIV3_SHIFT-1:DIV3_SHIFT];
    endfunction

    thpq_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign first_idx  = CH_W'(r_pos) + CH_W'({r_pos, 1'b0}) + CH_W'(1);
    assign count_ext  = CH_W'(r_count);
    assign parent_idx = div3(r_pos - ADDR_W'(1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_val       = r_val;
        n_pos       = r_pos;
        n_par       = r_par;
        n_first     = r_first;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_top       = r_top;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_val;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_top    = '0;
                    n_status = ST_OK;
                    if (i_in_req.op == OP_INSERT) begin
                        if (r_count >= CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_val   = i_in_req.value;
                            n_pos   = r_count[ADDR_W-1:0];
                            n_count = r_count + CNT_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_count   = r_count - CNT_W'(1);
                            n_state   = S_RM_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_idx;
                    n_par     = parent_idx;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (ranks_above(r_order_mode, mem_rdata, r_val)) begin
                    // Parent moves down into the hole; the hole climbs.
                    mem_wdata = mem_rdata;
                    n_pos     = r_par;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_LAST: begin
                n_top     = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = r_count[ADDR_W-1:0];
                n_state   = S_RM_LOAD;
            end
            S_RM_LOAD: begin
                n_val = mem_rdata;
                n_pos = '0;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD1;
                end
            end
            S_DN_RD1: begin
                if (first_idx >= count_ext) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = first_idx[ADDR_W-1:0];
                    n_first   = first_idx;
                    n_state   = S_DN_RD2;
                end
            end
            S_DN_RD2: begin
                n_best_val = mem_rdata;
                n_best_idx = r_first[ADDR_W-1:0];
                mem_re     = 1'b1;
                mem_raddr  = r_first[ADDR_W-1:0] + ADDR_W'(1);
                n_state    = S_DN_RD3;
            end
            S_DN_RD3: begin
                if ((r_first + CH_W'(1)) < count_ext &&
                    ranks_above(r_order_mode, r_best_val, mem_rdata)) begin
                    n_best_val = mem_rdata;
                    n_best_idx = r_first[ADDR_W-1:0] + ADDR_W'(1);
                end
                mem_re    = 1'b1;
                mem_raddr = r_first[ADDR_W-1:0] + ADDR_W'(2);
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                if ((r_first + CH_W'(2)) < count_ext &&
                    ranks_above(r_order_mode, r_best_val, mem_rdata)) begin
                    n_best_val = mem_rdata;
                    n_best_idx = r_first[ADDR_W-1:0] + ADDR_W'(2);
                end
                mem_we = 1'b1;
                if (ranks_above(r_order_mode, r_val, n_best_val)) begin
                    // Best child moves up; the sinking element follows it down.
                    mem_wdata = n_best_val;
                    n_pos     = n_best_idx;
                    n_state   = S_DN_RD1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.top_value      = r_top;
                    n_out.status         = r_status;
                    n_out.fill_count     = FILL_W'(r_count);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_order_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_order_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_par      <= n_par;
        r_first    <= n_first;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_top      <= n_top;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `THPQ_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "fill count above depth")
    `THPQ_ASSERT_ALWAYS(a_one_port_op, !(mem_we && mem_re), "store read and write together")
    `THPQ_ASSERT_IMPL(a_up_not_root, r_state == S_UP_CMP, r_pos != '0, "root compared upward")
    `THPQ_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE, "accepted request lost")

endmodule
